// ===== rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the positional list engine
// Operation codes, field widths, list capacity and the per-cell command.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 7;
  localparam int GRP_SZ = 8;
  localparam int GRP_N  = (DEPTH + GRP_SZ - 1) / GRP_SZ;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_SEARCH = 3'd4
  } plc_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_DONE
  } plc_state_t;

  // Broadcast to every cell; all flags are zero outside an accepted transaction
  typedef struct packed {
    logic             shift_in;
    logic             shift_out;
    logic             write;
    logic             get;
    logic             search;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } plc_cmd_t;

endpackage

// ===== rtl/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell: one list slot
// Holds one entry, shifts with its neighbors on insert/remove, and registers
// its search match and get read-out for the reduction stage.
// ----------------------------------------------------------------------------
module plc_cell (
  input  logic                     clk,
  input  logic [plc_pkg::IDX_W-1:0] cell_idx,
  input  plc_pkg::plc_cmd_t         cmd,
  input  logic [plc_pkg::VAL_W-1:0] left_data,
  input  logic [plc_pkg::VAL_W-1:0] right_data,
  output logic [plc_pkg::VAL_W-1:0] data,
  output logic                      hit,
  output logic [plc_pkg::VAL_W-1:0] rd
);
  import plc_pkg::*;

  logic [VAL_W-1:0] data_r, data_nxt;
  logic             hit_r, hit_nxt;
  logic [VAL_W-1:0] rd_r, rd_nxt;
  logic             at_slot;
  logic             past_slot;
  logic             live;

  always_comb begin
    at_slot   = (cell_idx == cmd.slot);
    past_slot = (cell_idx > cmd.slot);
    live      = (CNT_W'(cell_idx) < cmd.count);

    data_nxt = data_r;
    if ((cmd.shift_in || cmd.write) && at_slot) begin
      data_nxt = cmd.value;
    end else if (cmd.shift_in && past_slot) begin
      data_nxt = left_data;
    end else if (cmd.shift_out && (at_slot || past_slot)) begin
      data_nxt = right_data;
    end

    hit_nxt = cmd.search && live && (data_r == cmd.value);
    rd_nxt  = (cmd.get && at_slot) ? data_r : '0;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
    rd_r   <= rd_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;
  assign rd   = rd_r;

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values in a cell row
// Insert/remove shift the row by one cell, get/set address one cell, search
// compares every live cell; a registered OR tree gathers the answers.
// ----------------------------------------------------------------------------
//  channel  ports                                         handshake
//  input    in_operation, in_position, in_value           start & !busy
//  result   out_ok, out_read_value, out_found, out_length out_strobe, 1 cycle
//
//  Per transaction the cells update and register their match and read bits,
//  the group OR registers load, then the result registers.
//  busy is high while the state is ST_CELL or ST_DONE; a new transaction can
//  be accepted in the cycle the previous result is on the ports.
//  Synchronous reset clears the count and the control state only.
//  The receiver cannot stall; each result is flagged by out_strobe for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [plc_pkg::OP_W-1:0]  in_operation,
  input  logic [plc_pkg::POS_W-1:0] in_position,
  input  logic signed [plc_pkg::VAL_W-1:0] in_value,
  output logic                      out_strobe,
  output logic                      out_ok,
  output logic signed [plc_pkg::VAL_W-1:0] out_read_value,
  output logic                      out_found,
  output logic [plc_pkg::LEN_W-1:0] out_length
);
  import plc_pkg::*;

  plc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ok_r, ok_nxt;
  logic             search_r, search_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  logic             out_ok_r;
  logic [VAL_W-1:0] out_rd_r;
  logic             out_found_r;
  logic [LEN_W-1:0] out_len_r;

  logic             grp_hit_r [GRP_N];
  logic [VAL_W-1:0] grp_rd_r  [GRP_N];
  logic             grp_hit_nxt [GRP_N];
  logic [VAL_W-1:0] grp_rd_nxt  [GRP_N];

  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] cell_left [DEPTH];
  logic [VAL_W-1:0] cell_right[DEPTH];
  logic             cell_hit  [DEPTH];
  logic [VAL_W-1:0] cell_rd   [DEPTH];

  logic             accept;
  logic             pos_nz;
  logic             pos_live;
  logic             ins_ok;
  logic             all_hit;
  logic [VAL_W-1:0] all_rd;
  plc_cmd_t         cmd;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    pos_nz   = (in_position != '0);
    pos_live = pos_nz && ({1'b0, in_position} <= (CNT_W + 1)'(count_r));
    ins_ok   = pos_nz && ({1'b0, in_position} <= ((CNT_W + 1)'(count_r) + 1'b1))
               && (count_r < CNT_W'(DEPTH));

    cmd       = '0;
    cmd.slot  = IDX_W'(in_position - POS_W'(1));
    cmd.count = count_r;
    cmd.value = in_value;

    count_nxt  = count_r;
    ok_nxt     = ok_r;
    search_nxt = search_r;

    if (accept) begin
      ok_nxt     = 1'b0;
      search_nxt = 1'b0;
      case (plc_op_t'(in_operation))
        OP_INSERT: begin
          cmd.shift_in = ins_ok;
          ok_nxt       = ins_ok;
          if (ins_ok) begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          cmd.shift_out = pos_live;
          ok_nxt        = pos_live;
          if (pos_live) begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_GET: begin
          cmd.get = pos_live;
          ok_nxt  = pos_live;
        end
        OP_SET: begin
          cmd.write = pos_live;
          ok_nxt    = pos_live;
        end
        OP_SEARCH: begin
          cmd.search = 1'b1;
          ok_nxt     = 1'b1;
          search_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign cell_left[gi] = '0;
      end else begin : g_mid_l
        assign cell_left[gi] = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign cell_right[gi] = '0;
      end else begin : g_mid_r
        assign cell_right[gi] = cell_data[gi+1];
      end

      plc_cell u_cell (
        .clk        (clk),
        .cell_idx   (IDX_W'(gi)),
        .cmd        (cmd),
        .left_data  (cell_left[gi]),
        .right_data (cell_right[gi]),
        .data       (cell_data[gi]),
        .hit        (cell_hit[gi]),
        .rd         (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_rd_nxt[g]  = '0;
      for (int m = 0; m < GRP_SZ; m++) begin
        if (g * GRP_SZ + m < DEPTH) begin
          grp_hit_nxt[g] = grp_hit_nxt[g] | cell_hit[g * GRP_SZ + m];
          grp_rd_nxt[g]  = grp_rd_nxt[g] | cell_rd[g * GRP_SZ + m];
        end
      end
    end
    all_hit = 1'b0;
    all_rd  = '0;
    for (int g = 0; g < GRP_N; g++) begin
      all_hit = all_hit | grp_hit_r[g];
      all_rd  = all_rd | grp_rd_r[g];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CELL;
        end
      end
      ST_CELL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ok_r         <= 1'b0;
      search_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ok_r         <= ok_nxt;
      search_r     <= search_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_hit_r[g] <= grp_hit_nxt[g];
      grp_rd_r[g]  <= grp_rd_nxt[g];
    end
    if (state_r == ST_DONE) begin
      out_ok_r    <= ok_r;
      out_rd_r    <= all_rd;
      out_found_r <= search_r && all_hit;
      out_len_r   <= LEN_W'(count_r);
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_found      = out_found_r;
  assign out_length     = out_len_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count above capacity");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CELL) ##1 (state_r == ST_DONE) ##1 out_strobe)
    else $error("transaction did not complete in three cycles");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> $past(accept))
    else $error("count changed without a transaction");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found |-> out_ok)
    else $error("found reported on failed transaction");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_DONE))
    else $error("result strobe without completion");

endmodule
